// ===== rtl/bkv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bkv_pkg;

   // fixed field widths
   localparam int BUCKET_W    = 12;
   localparam int MULT_W      = 12;
   localparam int SHIFT_W     = 3;
   localparam int THR_W       = 8;
   localparam int LOC_OUT_W   = 12;
   localparam int SCORE_OUT_W = 8;
   localparam int HIT_W       = 13;
   localparam int HIT_NUM_W   = 12;
   localparam int POS_W       = 6;
   localparam int WIN_W       = 7;

   // port widths
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 12;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = RSP_TDATA_W - LOC_OUT_W - SCORE_OUT_W - 1 - HIT_NUM_W - 1;

   // limits and reset values
   localparam logic [SHIFT_W-1:0] MAX_SHIFT     = 3'd6;
   localparam logic [HIT_W-1:0]   HIT_MAX       = 13'd8191;
   localparam logic [MULT_W-1:0]  MULT_RESET    = 12'd1;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 3'd4;
   localparam logic [THR_W-1:0]   THR_RESET     = 8'd2;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MULTIPLIER     = 2'd0,
      CSR_BUCKET_SHIFT   = 2'd1,
      CSR_VOTE_THRESHOLD = 2'd2
   } csr_index_type;

   // input item kinds
   typedef enum logic {
      KIND_VOTE  = 1'b0,
      KIND_CLEAR = 1'b1
   } kind_type;

   // one window position handed to the update stage
   typedef struct packed {
      logic valid;
      logic last;
      logic round_end;
   } issue_type;

   // update stage status back to the sequencer
   typedef struct packed {
      logic busy;
      logic advance;
   } upd_stat_type;

endpackage

`default_nettype wire

// ===== rtl/bkv_score_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bkv_score_ram #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem_ff [0:DEPTH-1];
   logic [DATA_W-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/bkv_score_update.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bkv_score_update #(
   parameter int N_LOG2     = 12,
   parameter int SCORE_BITS = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire bkv_pkg::issue_type                 issue,
   input  wire logic [N_LOG2-1:0]                  issue_loc,
   input  wire logic [bkv_pkg::THR_W-1:0]          threshold,
   input  wire logic                               hit_clear,
   input  wire logic [SCORE_BITS-1:0]              rd_data,
   output logic      [N_LOG2-1:0]                  rd_addr,
   output logic                                    wr_en,
   output logic      [N_LOG2-1:0]                  wr_addr,
   output logic      [SCORE_BITS-1:0]              wr_data,
   output bkv_pkg::upd_stat_type                   stat,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [bkv_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                    rsp_tlast
);

   localparam int LOC_EXT_W = (N_LOG2 > bkv_pkg::LOC_OUT_W) ? N_LOG2 : bkv_pkg::LOC_OUT_W;
   localparam int SC_EXT_W  = (SCORE_BITS > bkv_pkg::THR_W) ? SCORE_BITS : bkv_pkg::THR_W;
   localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

   logic                              m_valid_ff, m_valid_in;
   logic                              m_last_ff;
   logic                              m_round_end_ff;
   logic [N_LOG2-1:0]                 m_loc_ff;
   logic                              fwd_ff, fwd_in;
   logic [SCORE_BITS-1:0]             fwd_data_ff;
   logic [bkv_pkg::HIT_W-1:0]         hit_total_ff, hit_total_in;
   logic                              out_valid_ff, out_valid_in;
   logic [bkv_pkg::RSP_TDATA_W-1:0]   out_data_ff, out_data_in;
   logic                              out_last_ff;

   logic                              advance;
   logic [SCORE_BITS-1:0]             cur_score;
   logic                              not_sat;
   logic [SCORE_BITS-1:0]             score_new;
   logic                              hit;
   logic [bkv_pkg::HIT_NUM_W-1:0]     hit_num;
   logic [LOC_EXT_W-1:0]              loc_ext;
   logic [SC_EXT_W-1:0]               score_ext;

   // stage moves when the output slot is free or being emptied
   assign advance = m_valid_ff && (!out_valid_ff || rsp_tready);
   assign stat.busy    = m_valid_ff;
   assign stat.advance = advance;

   // re-read the held entry while stalled, so its data stays current
   assign rd_addr = issue.valid ? issue_loc : m_loc_ff;

   // forward the value written in the cycle of the read
   assign cur_score = fwd_ff ? fwd_data_ff : rd_data;

   // saturating increment and threshold check
   assign not_sat   = (cur_score != SCORE_MAX);
   assign score_new = not_sat ? SCORE_BITS'(cur_score + 1'b1) : cur_score;
   assign hit       = not_sat && (SC_EXT_W'(score_new) == SC_EXT_W'(threshold));
   assign hit_num   = hit ? hit_total_ff[bkv_pkg::HIT_NUM_W-1:0] : '0;

   // write back
   assign wr_en   = advance;
   assign wr_addr = m_loc_ff;
   assign wr_data = score_new;
   assign fwd_in  = wr_en && (wr_addr == rd_addr);

   // result packing
   assign loc_ext   = LOC_EXT_W'(m_loc_ff);
   assign score_ext = SC_EXT_W'(score_new);
   assign out_data_in = {{bkv_pkg::RSP_PAD_W{1'b0}},
                         m_round_end_ff,
                         hit_num,
                         hit,
                         score_ext[bkv_pkg::SCORE_OUT_W-1:0],
                         loc_ext[bkv_pkg::LOC_OUT_W-1:0]};

   // stage occupancy
   always_comb begin
      m_valid_in = m_valid_ff;
      if (issue.valid) begin
         m_valid_in = 1'b1;
      end else if (advance) begin
         m_valid_in = 1'b0;
      end
   end

   // hit counter, saturating
   always_comb begin
      hit_total_in = hit_total_ff;
      if (hit_clear) begin
         hit_total_in = '0;
      end else if (advance && hit && (hit_total_ff != bkv_pkg::HIT_MAX)) begin
         hit_total_in = hit_total_ff + 1'b1;
      end
   end

   // output slot
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
         hit_total_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         m_valid_ff   <= m_valid_in;
         fwd_ff       <= fwd_in;
         hit_total_ff <= hit_total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      fwd_data_ff <= wr_data;
      if (issue.valid) begin
         m_loc_ff       <= issue_loc;
         m_last_ff      <= issue.last;
         m_round_end_ff <= issue.round_end;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
         out_last_ff <= m_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ===== rtl/bucket_location_voting_top.sv =====
// Bucket location voting for a sparse FFT.
// req channel: one item per large bucket (tuser = kind, tlast = last bucket of
// the round, tdata = bucket index). A vote item walks the bucket's window of
// 2^bucket_shift permuted indices (shift capped at 6), adds one to the score of
// each mapped location and sends one rsp item per window position; tlast marks
// the last result of the item. A clear item zeroes scores and the hit count and
// sends nothing.
// csr channel: index/data writes of multiplier, bucket_shift and vote_threshold,
// always ready; write them only while the block is idle.
// Score memory: one read-modify-write per cycle, unless a stall on rsp holds
// the update stage, through its single read and write port, with the written
// value forwarded to a read of the same entry in the next position. After
// accept, the first result passes through ST_SETUP, ST_WALK, the update stage
// and the result register. A clear item and reset both sweep the 2^N_LOG2-entry
// score memory, one entry a cycle, with req_tready low meanwhile.
// A stall on rsp holds the update stage and the result register; the walk
// pauses and resumes with no result lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module bucket_location_voting_top #(
   parameter int N_LOG2     = 12,
   parameter int SCORE_BITS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // bucket[11:0]
   input  wire logic [bkv_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // kind
   input  wire logic                                req_tuser,
   input  wire logic                                req_tlast,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // location[11:0], new_score[19:12], new_hit[20], hit_number[32:21],
   // round_end[33]
   output logic      [bkv_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                     rsp_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [bkv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [bkv_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int MW = (N_LOG2 > bkv_pkg::MULT_W) ? N_LOG2 : bkv_pkg::MULT_W;
   localparam int SW = ((N_LOG2 > bkv_pkg::BUCKET_W) ? N_LOG2 : bkv_pkg::BUCKET_W)
                       + bkv_pkg::WIN_W;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_SETUP = 5'b00100,
      ST_WALK  = 5'b01000,
      ST_DRAIN = 5'b10000
   } state_type;

   state_type                       state_ff, state_in;
   logic [bkv_pkg::MULT_W-1:0]      mult_ff;
   logic [bkv_pkg::SHIFT_W-1:0]     shift_ff;
   logic [bkv_pkg::THR_W-1:0]       thr_ff;
   logic [N_LOG2-1:0]               clr_ff, clr_in;
   logic [N_LOG2-1:0]               start_ff, start_in;
   logic [N_LOG2-1:0]               loc_ff, loc_in;
   logic [bkv_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [bkv_pkg::POS_W-1:0]       last_pos_ff, last_pos_in;
   logic                            final_ff, final_in;

   logic                            req_accept;
   logic                            is_clear;
   logic [bkv_pkg::BUCKET_W-1:0]    bucket;
   logic [bkv_pkg::SHIFT_W-1:0]     sh_clip;
   logic [bkv_pkg::WIN_W-1:0]       win;
   logic [bkv_pkg::WIN_W-1:0]       win_m1;
   logic                            empty_win;
   logic [SW-1:0]                   start_wide;
   logic [MW-1:0]                   mult_ext;
   logic [N_LOG2-1:0]               mult_idx;
   logic [N_LOG2-1:0]               prod_lo;
   logic                            at_last;
   logic                            hit_clear;

   bkv_pkg::issue_type              issue;
   bkv_pkg::upd_stat_type           stat;
   logic [N_LOG2-1:0]               rd_addr;
   logic [SCORE_BITS-1:0]           rd_data;
   logic                            upd_wr_en;
   logic [N_LOG2-1:0]               upd_wr_addr;
   logic [SCORE_BITS-1:0]           upd_wr_data;
   logic                            mem_wr_en;
   logic [N_LOG2-1:0]               mem_wr_addr;
   logic [SCORE_BITS-1:0]           mem_wr_data;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff  <= bkv_pkg::MULT_RESET;
         shift_ff <= bkv_pkg::SHIFT_RESET;
         thr_ff   <= bkv_pkg::THR_RESET;
      end else if (csr_valid) begin
         case (bkv_pkg::csr_index_type'(csr_index))
            bkv_pkg::CSR_MULTIPLIER: begin
               mult_ff <= csr_data[bkv_pkg::MULT_W-1:0];
            end
            bkv_pkg::CSR_BUCKET_SHIFT: begin
               shift_ff <= csr_data[bkv_pkg::SHIFT_W-1:0];
            end
            bkv_pkg::CSR_VOTE_THRESHOLD: begin
               thr_ff <= csr_data[bkv_pkg::THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // item decode
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign is_clear   = (bkv_pkg::kind_type'(req_tuser) == bkv_pkg::KIND_CLEAR);
   assign bucket     = req_tdata[bkv_pkg::BUCKET_W-1:0];
   assign hit_clear  = req_accept && is_clear;

   // window geometry: start = bucket*w - w/2 mod n, empty when w is a multiple of n
   assign sh_clip    = (shift_ff > bkv_pkg::MAX_SHIFT) ? bkv_pkg::MAX_SHIFT : shift_ff;
   assign win        = bkv_pkg::WIN_W'(1) << sh_clip;
   assign win_m1     = win - bkv_pkg::WIN_W'(1);
   assign empty_win  = (32'(sh_clip) >= 32'(N_LOG2));
   assign start_wide = (SW'(bucket) << sh_clip) - SW'(win >> 1);
   assign start_in   = start_wide[N_LOG2-1:0];
   assign last_pos_in = win_m1[bkv_pkg::POS_W-1:0];
   assign final_in    = req_tlast;

   // multiplier taken mod n
   assign mult_ext = MW'(mult_ff);
   assign mult_idx = mult_ext[N_LOG2-1:0];

   // first location of the walk, low bits of the product only
   assign prod_lo = start_ff * mult_idx;

   // walk issue
   assign at_last         = (pos_ff == last_pos_ff);
   assign issue.valid     = (state_ff == ST_WALK) && (!stat.busy || stat.advance);
   assign issue.last      = at_last;
   assign issue.round_end = at_last && final_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      loc_in   = loc_ff;
      pos_in   = pos_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               if (is_clear) begin
                  clr_in   = '0;
                  state_in = ST_CLEAR;
               end else if (!empty_win) begin
                  pos_in   = '0;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            loc_in   = prod_lo;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (issue.valid) begin
               loc_in = loc_ff + mult_idx;
               pos_in = pos_ff + 1'b1;
               if (at_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (stat.advance) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // walk payload
   always_ff @(posedge clock) begin
      loc_ff <= loc_in;
      pos_ff <= pos_in;
      if (req_accept) begin
         start_ff    <= start_in;
         last_pos_ff <= last_pos_in;
         final_ff    <= final_in;
      end
   end

   // memory write port: clearing sweep or score write-back
   assign mem_wr_en   = (state_ff == ST_CLEAR) || upd_wr_en;
   assign mem_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : upd_wr_addr;
   assign mem_wr_data = (state_ff == ST_CLEAR) ? '0 : upd_wr_data;

   bkv_score_ram #(
      .ADDR_W (N_LOG2),
      .DATA_W (SCORE_BITS)
   ) u_score_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bkv_score_update #(
      .N_LOG2     (N_LOG2),
      .SCORE_BITS (SCORE_BITS)
   ) u_score_update (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .issue_loc  (loc_ff),
      .threshold  (thr_ff),
      .hit_clear  (hit_clear),
      .rd_data    (rd_data),
      .rd_addr    (rd_addr),
      .wr_en      (upd_wr_en),
      .wr_addr    (upd_wr_addr),
      .wr_data    (upd_wr_data),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
